FILE: design/m3i_pkg.sv
// shared constants for the 3x3 matrix inverse pipeline
// no dependencies; used by m3i_div and matrix3x3_inverse
package m3i_pkg;

  localparam int ELEM_WIDTH = 24;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ELEM   = 9;
  // stages ahead of the divider: input, products, cofactors, det partials, det sum, magnitudes
  localparam int PRE_STAGES = 6;

  // element indexes (row * 3 + col) of the two products per cofactor,
  // cofactor k = a[MUL_A[2k]] * a[MUL_B[2k]] - a[MUL_A[2k+1]] * a[MUL_B[2k+1]]
  localparam int MUL_A [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int MUL_B [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

FILE: design/m3i_div.sv
// pipelined restoring divider with saturation, one quotient bit per stage
// depends on m3i_pkg for parameter defaults
module m3i_div #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic [ELEM_WIDTH+1:0]               en,
  input  logic [2*ELEM_WIDTH:0]               mag,
  input  logic [((3*ELEM_WIDTH+3 > 3*FRAC_BITS+1) ?
                 3*ELEM_WIDTH+3 : 3*FRAC_BITS+1)-1:0] dmag,
  input  logic                                neg,
  output logic [ELEM_WIDTH-1:0]               quo
);

  localparam int W   = ELEM_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NW  = 2*W + 1;
  localparam int DW  = 3*W + 3;
  localparam int DMW = (DW > 3*F+1) ? DW : 3*F+1;
  localparam int NNW = NW + 2*F;
  localparam int RW  = DMW + W;
  localparam int XW  = (NNW > RW) ? NNW : RW;

  logic [RW-1:0]  rem [W+1];
  logic [DMW-1:0] dv  [W+1];
  logic [W-1:0]   qv  [W+1];
  logic           sat [W+1];
  logic           ng  [W+1];

  logic [XW-1:0] num_x;
  logic [XW-1:0] den_x;
  logic [W-1:0]  res;

  assign num_x = XW'(mag) << (2*F);
  assign den_x = XW'(dmag) << W;

  // quotient of 2^W or more saturates, checked up front
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= num_x[RW-1:0];
      dv[0]  <= dmag;
      qv[0]  <= '0;
      sat[0] <= (num_x >= den_x);
      ng[0]  <= neg;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_bit
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dv[j-1]) << (W-j);
    assign ge  = (rem[j-1] >= dsh);
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= ge ? (rem[j-1] - dsh) : rem[j-1];
        qv[j]  <= qv[j-1] | (ge ? (W'(1) << (W-j)) : W'(0));
        dv[j]  <= dv[j-1];
        sat[j] <= sat[j-1];
        ng[j]  <= ng[j-1];
      end
    end
  end

  // sign and clamp to the element range
  always_comb begin
    if (sat[W]) begin
      res = ng[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else if (!ng[W]) begin
      res = qv[W][W-1] ? {1'b0, {(W-1){1'b1}}} : qv[W];
    end else begin
      res = (qv[W][W-1] && (|qv[W][W-2:0])) ? {1'b1, {(W-1){1'b0}}} : (W'(0) - qv[W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[W+1]) begin
      quo <= res;
    end
  end

endmodule

FILE: design/matrix3x3_inverse.sv
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
// throughput: one matrix per cycle while m_tready stays high; the divider retires one quotient bit per stage
// each stage holds its beat under backpressure and fills bubbles independently
// reset (rst, synchronous, active high) clears all stage valid bits; no other state
// depends on m3i_pkg and m3i_div
module matrix3x3_inverse #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // a_r0c0, a_r0c1, a_r0c2, a_r1c0, ... a_r2c2, zero padded to bytes
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]         s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, ... inv_r2c2, zero padded to bytes
  output logic [((9*ELEM_WIDTH+7)/8)*8-1:0]         m_tdata,
  // det_was_zero
  output logic [0:0]                                m_tuser
);

  localparam int W    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NE   = m3i_pkg::NUM_ELEM;
  localparam int PRE  = m3i_pkg::PRE_STAGES;
  localparam int NST  = PRE + W + 2;
  localparam int CW   = 2*W + 1;
  localparam int DW   = 3*W + 3;
  localparam int DMW  = (DW > 3*F+1) ? DW : 3*F+1;
  localparam int DATW = NE * W;
  localparam int TDW  = ((9*ELEM_WIDTH+7)/8)*8;

  // per-stage valid and ready; a stage loads whenever it is empty or its
  // successor moves, so bubbles close up under backpressure
  logic [NST-1:0] valid;
  logic [NST-1:0] ready;

  for (genvar k = 0; k < NST; k++) begin : g_rdy
    if (k == NST-1) begin : g_last
      assign ready[k] = !valid[k] || m_tready;
    end else begin : g_mid
      assign ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign s_tready = ready[0];
  assign m_tvalid = valid[NST-1];

  // stage 0: input beat
  logic signed [W-1:0] a0 [NE];
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      for (int i = 0; i < NE; i++) begin
        a0[i] <= $signed(s_tdata[i*W +: W]);
      end
    end
  end

  // stage 1: the eighteen 2x2 minor products
  logic signed [2*W-1:0] pp1 [2*NE];
  logic signed [W-1:0]   ac1 [3];
  for (genvar n = 0; n < 2*NE; n++) begin : g_pp
    always_ff @(posedge clk) begin
      if (ready[1]) begin
        pp1[n] <= a0[m3i_pkg::MUL_A[n]] * a0[m3i_pkg::MUL_B[n]];
      end
    end
  end
  // first column rides along for the determinant
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      for (int t = 0; t < 3; t++) begin
        ac1[t] <= a0[3*t];
      end
    end
  end

  // stage 2: adjugate entries, sign already folded into the product order
  logic signed [CW-1:0] cof2 [NE];
  logic signed [W-1:0]  ac2  [3];
  always_ff @(posedge clk) begin
    if (ready[2]) begin
      for (int k = 0; k < NE; k++) begin
        cof2[k] <= CW'(pp1[2*k]) - CW'(pp1[2*k+1]);
      end
      for (int t = 0; t < 3; t++) begin
        ac2[t] <= ac1[t];
      end
    end
  end

  // stage 3: determinant partial products, cofactor split into high and low halves
  logic signed [2*W+1:0] dlo3 [3];
  logic signed [2*W-1:0] dhi3 [3];
  logic signed [CW-1:0]  cof3 [NE];
  always_ff @(posedge clk) begin
    if (ready[3]) begin
      for (int t = 0; t < 3; t++) begin
        dlo3[t] <= ac2[t] * $signed({1'b0, cof2[t][W:0]});
        dhi3[t] <= ac2[t] * $signed(cof2[t][CW-1:W+1]);
      end
      cof3 <= cof2;
    end
  end

  // stage 4: determinant, expansion down the first column
  logic signed [DW-1:0] det4;
  logic signed [CW-1:0] cof4 [NE];
  logic signed [DW-1:0] det_sum;
  always_comb begin
    det_sum = '0;
    for (int t = 0; t < 3; t++) begin
      det_sum = det_sum + DW'(dlo3[t]) + (DW'(dhi3[t]) <<< (W+1));
    end
  end
  always_ff @(posedge clk) begin
    if (ready[4]) begin
      det4 <= det_sum;
      cof4 <= cof3;
    end
  end

  // stage 5: magnitudes and quotient signs; zero determinant divides by one
  logic [DMW-1:0] dmag5;
  logic           zero5;
  logic [CW-1:0]  mag5 [NE];
  logic           ng5  [NE];
  logic           det_zero;
  logic           det_neg;
  assign det_zero = (det4 == '0);
  assign det_neg  = det4[DW-1];
  always_ff @(posedge clk) begin
    if (ready[5]) begin
      zero5 <= det_zero;
      if (det_zero) begin
        dmag5 <= DMW'(1) << (3*F);
      end else begin
        dmag5 <= DMW'(det_neg ? (DW'(0) - $unsigned(det4)) : $unsigned(det4));
      end
      for (int k = 0; k < NE; k++) begin
        mag5[k] <= cof4[k][CW-1] ? (CW'(0) - $unsigned(cof4[k])) : $unsigned(cof4[k]);
        ng5[k]  <= cof4[k][CW-1] ^ det_neg;
      end
    end
  end

  // zero-determinant flag travels beside the divider stages
  logic zf [PRE:NST-1];
  for (genvar k = PRE; k < NST; k++) begin : g_zf
    if (k == PRE) begin : g_first
      always_ff @(posedge clk) begin
        if (ready[k]) begin
          zf[k] <= zero5;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (ready[k]) begin
          zf[k] <= zf[k-1];
        end
      end
    end
  end

  // divider stages: nine lanes sharing the stage enables
  logic [W-1:0]    quo [NE];
  logic [DATW-1:0] flat;
  for (genvar k = 0; k < NE; k++) begin : g_div
    m3i_div #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div (
      .clk  (clk),
      .en   (ready[NST-1:PRE]),
      .mag  (mag5[k]),
      .dmag (dmag5),
      .neg  (ng5[k]),
      .quo  (quo[k])
    );
    assign flat[k*W +: W] = quo[k];
  end

  assign m_tdata    = TDW'(flat);
  assign m_tuser[0] = zf[NST-1];

  // a zero determinant must present a divisor of exactly one
  a_zero_div_one : assert property (@(posedge clk) disable iff (rst)
    valid[5] && zero5 |-> dmag5 == (DMW'(1) << (3*F)))
    else $error("zero determinant without unit divisor");

  // an accepted beat occupies the first stage next cycle
  a_accept_lands : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> valid[0])
    else $error("accepted beat lost at input stage");

  // a stalled beat in the determinant stage keeps its value
  a_det_hold : assert property (@(posedge clk) disable iff (rst)
    valid[4] && !ready[4] |=> valid[4] && $stable(det4))
    else $error("stalled determinant changed");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for matrix3x3_inverse: directed table, then random matrices
// depends on m3i_pkg and the matrix3x3_inverse rtl; expected inverses come from a local model
module tb;

  localparam int W = m3i_pkg::ELEM_WIDTH;
  localparam int DW = 9 * W;
  localparam int NUM_RANDOM = 1890;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_STRETCH = 300;
  localparam logic [W-1:0] ONE = 24'h010000;
  localparam logic [W-1:0] HALF = 24'h008000;
  localparam logic [W-1:0] LSB = 24'h000001;
  localparam logic [W-1:0] NEG_LSB = 24'hFFFFFF;
  localparam logic [W-1:0] MAXV = 24'h7FFFFF;
  localparam logic [W-1:0] MINV = 24'h800000;

  typedef struct packed {
    logic [DW-1:0] inv;
    logic          zero_det;
  } inverse_t;

  typedef struct {
    logic [DW-1:0] mat;
    bit            typed;
    inverse_t      known;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic [0:0] m_tuser;

  inverse_t pending_inv[$];
  int errors = 0;
  int in_beats = 0;
  int out_beats = 0;
  int idle_phase = 0;   // 0: receiver mostly stalls, 1: sender mostly idles, 2: no idling
  int stall_left = 0;
  bit stall_done = 1'b0;
  int quiet_cycles = 0;

  matrix3x3_inverse dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DW-1:0] pack9(input logic [W-1:0] e0, e1, e2, e3, e4,
                                          e5, e6, e7, e8);
    return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
  endfunction

  // whole number as a fixed-point element
  function automatic logic [W-1:0] fxi(input int n);
    return W'(n <<< m3i_pkg::FRAC_BITS);
  endfunction

  // adjugate over determinant, exact in 128 bits, quotient truncated then saturated
  function automatic inverse_t predict_inverse(input logic [DW-1:0] mat);
    logic signed [127:0] e[9];
    logic signed [127:0] c[9];
    logic signed [127:0] det;
    logic [127:0] dmag, num, quo;
    logic [W-1:0] q;
    bit dneg, neg;
    inverse_t r;
    for (int i = 0; i < 9; i++) begin
      e[i] = signed'(mat[i*W +: W]);
    end
    c[0] = e[4] * e[8] - e[5] * e[7];
    c[1] = -(e[1] * e[8] - e[2] * e[7]);
    c[2] = e[1] * e[5] - e[2] * e[4];
    c[3] = -(e[3] * e[8] - e[5] * e[6]);
    c[4] = e[0] * e[8] - e[2] * e[6];
    c[5] = -(e[0] * e[5] - e[2] * e[3]);
    c[6] = e[3] * e[7] - e[4] * e[6];
    c[7] = -(e[0] * e[7] - e[1] * e[6]);
    c[8] = e[0] * e[4] - e[1] * e[3];
    // expansion along the first column
    det = e[0] * c[0] + e[3] * c[1] + e[6] * c[2];
    r.zero_det = (det == 0);
    if (r.zero_det) begin
      // singular: divide by 1.0 at the determinant's scale
      dmag = 128'd1 << (3 * m3i_pkg::FRAC_BITS);
      dneg = 1'b0;
    end else begin
      dneg = det < 0;
      dmag = dneg ? -det : det;
    end
    for (int i = 0; i < 9; i++) begin
      neg = (c[i] < 0) != dneg;
      num = (c[i] < 0) ? -c[i] : c[i];
      num = num << (2 * m3i_pkg::FRAC_BITS);
      quo = num / dmag;
      if (!neg) q = (quo > 128'(MAXV)) ? MAXV : quo[W-1:0];
      else q = (quo > 128'(MINV)) ? MINV : W'(-quo);
      r.inv[i*W +: W] = q;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] small_elem();
    return W'($urandom_range(0, 2 << m3i_pkg::FRAC_BITS) - (1 << m3i_pkg::FRAC_BITS));
  endfunction

  // mostly well-conditioned small matrices, plus full-range, singular and near-diagonal ones
  function automatic logic [DW-1:0] random_matrix();
    logic [DW-1:0] m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      m[i*W +: W] = small_elem();
    end
    if (kind < 2) begin
      for (int i = 0; i < 9; i++) begin
        m[i*W +: W] = W'($urandom());
      end
    end else if (kind < 4) begin
      // repeat a row or a column so the determinant is zero
      if ($urandom_range(0, 1)) begin
        m[6*W +: 3*W] = m[0 +: 3*W];
      end else begin
        for (int r = 0; r < 3; r++) begin
          m[(3*r+2)*W +: W] = m[(3*r)*W +: W];
        end
      end
    end else if (kind < 6) begin
      for (int i = 0; i < 9; i++) begin
        if (i % 4 != 0) m[i*W +: W] = W'($urandom_range(0, 512) - 256);
      end
    end
    return m;
  endfunction

  task automatic report(input string what, input int idx, input logic [W-1:0] got,
                        input logic [W-1:0] want);
    $display("mismatch at output beat %0d: %s got %h expected %h", idx, what, got, want);
    errors++;
  endtask

  // one matrix beat; idles first, then holds until the block takes it
  task automatic send_matrix(input logic [DW-1:0] mat, input bit typed,
                             input inverse_t known);
    int gap_pct;
    gap_pct = (idle_phase == 1) ? 83 : (idle_phase == 0 ? 12 : 0);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= mat;
    do @(posedge clk); while (!s_tready);
    pending_inv.push_back(typed ? known : predict_inverse(mat));
    in_beats++;
    if (in_beats == 630) idle_phase = 1;
    if (in_beats == 1260) idle_phase = 2;
    @(negedge clk);
  endtask

  // receiver: random stalls by phase, and one long hold-off so the pipeline backs up
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = (idle_phase == 0) ? 83 : (idle_phase == 1 ? 12 : 0);
    if (!stall_done && in_beats >= 900) begin
      stall_done <= 1'b1;
      stall_left <= STALL_STRETCH;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // output beat check against the oldest expected inverse
  always @(posedge clk) begin
    inverse_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_inv.size() == 0) begin
        report("unexpected beat", out_beats, m_tdata[W-1:0], '0);
      end else begin
        want = pending_inv.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_tdata[i*W +: W] !== want.inv[i*W +: W])
            report($sformatf("inv_r%0dc%0d", i / 3, i % 3), out_beats,
                   m_tdata[i*W +: W], want.inv[i*W +: W]);
        end
        if (m_tuser[0] !== want.zero_det)
          report("det_was_zero", out_beats, W'(m_tuser[0]), W'(want.zero_det));
      end
      out_beats++;
    end
  end

  // watchdog: cycles in a row with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    inverse_t k;
    // identity gives identity
    row.mat = pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE); row.typed = 1;
    row.known.inv = pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE); row.known.zero_det = 0;
    rows.push_back(row);
    // twice the identity gives one half on the diagonal
    row.mat = pack9(fxi(2), 0, 0, 0, fxi(2), 0, 0, 0, fxi(2));
    row.known.inv = pack9(HALF, 0, 0, 0, HALF, 0, 0, 0, HALF);
    rows.push_back(row);
    // zero matrix: singular, flag set, all zero
    row.mat = '0; row.known.inv = '0; row.known.zero_det = 1;
    rows.push_back(row);
    // all largest and all smallest: singular with zero cofactors
    row.mat = {9{MAXV}};
    rows.push_back(row);
    row.mat = {9{MINV}};
    rows.push_back(row);
    // one lsb on the diagonal: inverse overflows high
    row.mat = pack9(LSB, 0, 0, 0, LSB, 0, 0, 0, LSB); row.known.zero_det = 0;
    row.known.inv = pack9(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
    rows.push_back(row);
    // minus one lsb on the diagonal: inverse overflows low
    row.mat = pack9(NEG_LSB, 0, 0, 0, NEG_LSB, 0, 0, 0, NEG_LSB);
    row.known.inv = pack9(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
    rows.push_back(row);
    // the rest go through the predictor
    row.typed = 0;
    row.mat = pack9(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV); rows.push_back(row);
    row.mat = pack9(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV); rows.push_back(row);
    row.mat = pack9(MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, ONE); rows.push_back(row);
    row.mat = pack9(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV); rows.push_back(row);
    row.mat = pack9(0, ONE, 0, 0, 0, ONE, ONE, 0, 0); rows.push_back(row);
    row.mat = pack9(ONE, fxi(2), fxi(3), 0, ONE, fxi(4), fxi(5), fxi(6), 0);
    rows.push_back(row);
    // singular with nonzero cofactors: flag set, adjugate passes through truncated
    row.mat = pack9(ONE, fxi(2), fxi(3), fxi(4), fxi(5), fxi(6), fxi(7), fxi(8),
                    fxi(9));
    rows.push_back(row);
    row.mat = pack9(MAXV, LSB, 0, NEG_LSB, MAXV, MINV, 0, HALF, MAXV); rows.push_back(row);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (rows[i]) send_matrix(rows[i].mat, rows[i].typed, rows[i].known);
    k = '0;
    for (int n = 0; n < NUM_RANDOM; n++) send_matrix(random_matrix(), 1'b0, k);
    s_tvalid <= 1'b0;
    while (pending_inv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
